// ----- sv/wmmrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmrd_pkg
// shared widths and item types of the min / max / rms waveform decimator
// ----------------------------------------------------------------------------
package wmmrd_pkg;

  localparam int SAMPLE_W = 16;                 // signed sample, q1.15
  localparam int COUNT_W  = 16;                 // window length and bucket count
  localparam int SQ_W     = 2 * SAMPLE_W - 1;   // one squared magnitude
  localparam int SUM_W    = SQ_W + COUNT_W;     // exact sum of squares
  localparam int MEAN_W   = 2 * SAMPLE_W;       // mean square, never above 2^(2*SAMPLE_W-2)
  localparam int ROOT_W   = SAMPLE_W;           // floor of the root

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bucket_min;
    logic signed [SAMPLE_W-1:0] bucket_max;
    logic        [SAMPLE_W-1:0] bucket_rms;
    logic        [COUNT_W-1:0]  bucket_count;
    logic                       last_bucket;
  } out_item_t;

endpackage

// ----- sv/waveform_min_max_rms_decimator.sv -----
`timescale 1ns / 1ps
// sequence: a sample that does not close its bucket frees the input once its square steps
// are done (one bit-serial square step per multiplier bit up to its top set bit); a closing
// sample adds the 47-step bit-serial divide and the 16-step root, and its item then waits
// for the previous item to leave the output before it shows
// input: one sample at a time; the next sample is taken only once the last one is through
// reset: asynchronous active low; window length returns to one, bucket and output emptied
// ----------------------------------------------------------------------------
// waveform_min_max_rms_decimator
// groups samples into buckets and emits min, max, rms and count for each bucket
// ----------------------------------------------------------------------------
module waveform_min_max_rms_decimator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: window length in samples
  input  logic                               cfg_we_i,
  input  logic [wmmrd_pkg::COUNT_W-1:0]      cfg_wdata_i,
  // sample stream
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wmmrd_pkg::in_item_t                in_data_i,
  // bucket results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wmmrd_pkg::out_item_t               out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,   // waiting for a sample
    ST_MAC  = 4'b0010,   // squaring the sample into the running sum
    ST_DIV  = 4'b0100,   // sum of squares over count
    ST_SQRT = 4'b1000    // root of the mean square, then hand to output
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [wmmrd_pkg::COUNT_W-1:0] win_q;
  logic [wmmrd_pkg::COUNT_W-1:0] win_eff;

  // open bucket
  logic signed [wmmrd_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic signed [wmmrd_pkg::SAMPLE_W-1:0] max_q, max_d;
  logic        [wmmrd_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic                                  close_q, close_d;
  logic                                  eos_q, eos_d;

  // output register
  wmmrd_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // handshakes and unit control
  logic                              in_fire;
  logic                              first;
  logic [wmmrd_pkg::COUNT_W-1:0]     cnt_inc;
  logic signed [wmmrd_pkg::SAMPLE_W-1:0] smp;
  logic [wmmrd_pkg::SAMPLE_W-1:0]    mag;
  logic                              mac_busy, div_busy, sqrt_busy;
  logic                              div_start, sqrt_start, load_out;
  logic [wmmrd_pkg::SUM_W-1:0]       sum;
  logic [wmmrd_pkg::MEAN_W-1:0]      mean;
  logic [wmmrd_pkg::ROOT_W-1:0]      root;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;

  // zero window length acts as a window of one
  assign win_eff = (win_q == '0) ? wmmrd_pkg::COUNT_W'(1) : win_q;

  assign smp     = in_data_i.sample;
  // two's complement negate; the most negative code maps to its unsigned magnitude
  assign mag     = smp[wmmrd_pkg::SAMPLE_W-1] ? (~smp + 1'b1) : smp;
  assign first   = cnt_q == '0;
  // count never wraps: the bucket closes at the latest when it reaches the window
  assign cnt_inc = cnt_q + 1'b1;

  assign div_start  = (state_q == ST_MAC) && !mac_busy && close_q;
  assign sqrt_start = (state_q == ST_DIV) && !div_busy;
  // the output register takes a new bucket once the previous one is gone
  assign load_out   = (state_q == ST_SQRT) && !sqrt_busy && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (!mac_busy) begin
          state_d = close_q ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // bucket bookkeeping at sample acceptance, cleared once the result is out
  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    close_d = close_q;
    eos_d   = eos_q;
    if (in_fire) begin
      if (first || (smp < min_q)) begin
        min_d = smp;
      end
      if (first || (smp > max_q)) begin
        max_d = smp;
      end
      cnt_d   = cnt_inc;
      close_d = (cnt_inc >= win_eff) || in_data_i.end_of_stream;
      eos_d   = in_data_i.end_of_stream;
    end else if (load_out) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_d.bucket_min   = min_q;
      out_d.bucket_max   = max_q;
      out_d.bucket_rms   = root;
      out_d.bucket_count = cnt_q;
      out_d.last_bucket  = eos_q;
      out_valid_d        = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= wmmrd_pkg::COUNT_W'(1);
      min_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      close_q     <= 1'b0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      min_q       <= min_d;
      max_q       <= max_d;
      cnt_q       <= cnt_d;
      close_q     <= close_d;
      eos_q       <= eos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // square and accumulate; the sum restarts on the first sample of a bucket
  wmmrd_sqmac u_sqmac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .clear_i (first),
    .mag_i   (mag),
    .busy_o  (mac_busy),
    .sum_o   (sum)
  );

  // mean square = floor(sum / count)
  wmmrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quotient_o (mean)
  );

  // rms = floor(sqrt(mean square))
  wmmrd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (mean),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_accept_to_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MAC)
    else $error("accepted sample did not start the square step");

  a_idle_units_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!div_busy && !sqrt_busy))
    else $error("divider or root unit busy while idle");

  a_load_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (cnt_q == '0) && (out_q.bucket_count != '0))
    else $error("bucket count not cleared or result count zero");

  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.bucket_min <= out_q.bucket_max))
    else $error("bucket minimum above maximum");

endmodule

// ----- sv/wmmrd_sqmac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmrd_sqmac
// bit-serial square and accumulate: one multiplier bit per cycle
// ----------------------------------------------------------------------------
module wmmrd_sqmac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              clear_i,
  input  logic [wmmrd_pkg::SAMPLE_W-1:0]    mag_i,
  output logic                              busy_o,
  output logic [wmmrd_pkg::SUM_W-1:0]       sum_o
);

  logic [wmmrd_pkg::SQ_W-1:0]     mcand_q, mcand_d;
  logic [wmmrd_pkg::SAMPLE_W-1:0] mplier_q, mplier_d;
  logic [wmmrd_pkg::SUM_W-1:0]    sum_q, sum_d;

  assign busy_o = |mplier_q;
  assign sum_o  = sum_q;

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    sum_d    = sum_q;
    if (start_i) begin
      mcand_d  = wmmrd_pkg::SQ_W'(mag_i);
      mplier_d = mag_i;
      if (clear_i) begin
        sum_d = '0;
      end
    end else if (busy_o) begin
      if (mplier_q[0]) begin
        sum_d = sum_q + wmmrd_pkg::SUM_W'(mcand_q);
      end
      mcand_d  = {mcand_q[wmmrd_pkg::SQ_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[wmmrd_pkg::SAMPLE_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
      sum_q    <= '0;
    end else begin
      mplier_q <= mplier_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
  end

endmodule

// ----- sv/wmmrd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmrd_div
// restoring divider, one dividend bit per cycle, narrow remainder
// ----------------------------------------------------------------------------
module wmmrd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wmmrd_pkg::SUM_W-1:0]       dividend_i,
  input  logic [wmmrd_pkg::COUNT_W-1:0]     divisor_i,
  output logic                              busy_o,
  output logic [wmmrd_pkg::MEAN_W-1:0]      quotient_o
);

  localparam int STEP_W = $clog2(wmmrd_pkg::SUM_W + 1);

  logic [wmmrd_pkg::SUM_W-1:0]   dvd_q, dvd_d;
  logic [wmmrd_pkg::COUNT_W-1:0] dvs_q, dvs_d;
  logic [wmmrd_pkg::COUNT_W-1:0] rem_q, rem_d;
  logic [wmmrd_pkg::MEAN_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [wmmrd_pkg::COUNT_W:0]   rem_sh;
  logic                          fits;

  assign busy_o     = step_q != '0;
  assign quotient_o = quo_q;

  assign rem_sh = {rem_q, dvd_q[wmmrd_pkg::SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      step_d = STEP_W'(wmmrd_pkg::SUM_W);
    end else if (busy_o) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d  = fits ? wmmrd_pkg::COUNT_W'(rem_sh - {1'b0, dvs_q})
                    : wmmrd_pkg::COUNT_W'(rem_sh);
      quo_d  = {quo_q[wmmrd_pkg::MEAN_W-2:0], fits};
      dvd_d  = {dvd_q[wmmrd_pkg::SUM_W-2:0], 1'b0};
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

// ----- sv/wmmrd_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmmrd_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module wmmrd_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wmmrd_pkg::MEAN_W-1:0]      radicand_i,
  output logic                              busy_o,
  output logic [wmmrd_pkg::ROOT_W-1:0]      root_o
);

  localparam int STEP_W = $clog2(wmmrd_pkg::ROOT_W + 1);

  logic [wmmrd_pkg::MEAN_W-1:0] rad_q, rad_d;
  logic [wmmrd_pkg::ROOT_W-1:0] rem_q, rem_d;
  logic [wmmrd_pkg::ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [wmmrd_pkg::ROOT_W+1:0] rem_sh;
  logic [wmmrd_pkg::ROOT_W+1:0] trial;
  logic                         fits;

  assign busy_o = step_q != '0;
  assign root_o = root_q;

  // partial remainder never exceeds twice the partial root before the last bit
  assign rem_sh = {rem_q, rad_q[wmmrd_pkg::MEAN_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = STEP_W'(wmmrd_pkg::ROOT_W);
    end else if (busy_o) begin
      rem_d  = fits ? wmmrd_pkg::ROOT_W'(rem_sh - trial) : wmmrd_pkg::ROOT_W'(rem_sh);
      root_d = {root_q[wmmrd_pkg::ROOT_W-2:0], fits};
      rad_d  = {rad_q[wmmrd_pkg::MEAN_W-3:0], 2'b00};
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule
